### hdl/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

  localparam int MEM_UNITS_DEF    = 128;
  localparam int MAX_SEGMENTS_DEF = 16;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_NOTASK = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_SCAN  = 3'd2;
  localparam logic [2:0] OP_ALLOC = 3'd3;
  localparam logic [2:0] OP_REL   = 3'd4;
  localparam logic [2:0] OP_PRED  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       func;
    logic       split;
    logic       merge;
    logic [7:0] size;
    logic [7:0] id;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/ffsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell #(
  parameter int MEM_UNITS = ffsa_pkg::MEM_UNITS_DEF,
  parameter bit HEAD      = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ffsa_pkg::cmd_t cmd,
  input  wire logic [((MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1) + $clog2(MEM_UNITS + 1) + 13:0]
                             prev_i,
  input  wire logic [((MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1) + $clog2(MEM_UNITS + 1) + 13:0]
                             next_i,
  output logic      [((MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1) + $clog2(MEM_UNITS + 1) + 13:0]
                             self_o
);

  localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int LW = $clog2(MEM_UNITS + 1);
  localparam int CW = (LW > 8) ? LW : 8;

  typedef struct packed {
    logic          valid;
    logic          used;
    logic [7:0]    owner;
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic          hit;
    logic          first;
    logic          seen;
    logic          mark;
  } node_t;

  node_t prev, next;
  logic valid_r, valid_nxt, used_r, used_nxt, seen_r, seen_nxt, mark_r, mark_nxt;
  logic [7:0]    owner_r, owner_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic hit, first;

  assign prev = node_t'(prev_i);
  assign next = node_t'(next_i);

  always_comb begin
    if (cmd.func == ffsa_pkg::FUNC_RELEASE) begin
      hit = valid_r & used_r & (owner_r == cmd.id);
    end else begin
      hit = valid_r & ~used_r & (CW'(len_r) >= CW'(cmd.size)) & (cmd.size != 8'd0);
    end
    first = hit & ~seen_r;
  end

  assign self_o = {valid_r, used_r, owner_r, start_r, len_r, hit, first, seen_r, mark_r};

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    owner_nxt = owner_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    mark_nxt  = mark_r;
    unique case (cmd.op)
      ffsa_pkg::OP_CLEAR: begin
        seen_nxt = 1'b0;
        mark_nxt = 1'b0;
      end
      ffsa_pkg::OP_SCAN: seen_nxt = prev.seen | prev.hit;
      ffsa_pkg::OP_ALLOC: begin
        if (first) begin
          used_nxt  = 1'b1;
          owner_nxt = cmd.id;
          if (cmd.split) len_nxt = LW'(cmd.size);
        end else if (cmd.split && prev.first) begin
          valid_nxt = 1'b1;
          used_nxt  = 1'b0;
          owner_nxt = 8'd0;
          start_nxt = prev.start + AW'(cmd.size);
          len_nxt   = prev.len - LW'(cmd.size);
        end else if (cmd.split && prev.seen) begin
          valid_nxt = prev.valid;
          used_nxt  = prev.used;
          owner_nxt = prev.owner;
          start_nxt = prev.start;
          len_nxt   = prev.len;
        end
      end
      ffsa_pkg::OP_REL: begin
        mark_nxt = first;
        if (first) begin
          used_nxt  = 1'b0;
          owner_nxt = 8'd0;
          if (cmd.merge) len_nxt = len_r + next.len;
        end else if (cmd.merge && seen_r) begin
          valid_nxt = next.valid;
          used_nxt  = next.used;
          owner_nxt = next.owner;
          start_nxt = next.start;
          len_nxt   = next.len;
        end
      end
      ffsa_pkg::OP_PRED: begin
        if (next.mark) begin
          len_nxt = len_r + next.len;
        end else if (mark_r || seen_r) begin
          valid_nxt = next.valid;
          used_nxt  = next.used;
          owner_nxt = next.owner;
          start_nxt = next.start;
          len_nxt   = next.len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= HEAD;
      used_r  <= 1'b0;
      start_r <= '0;
      len_r   <= HEAD ? LW'(MEM_UNITS) : '0;
      seen_r  <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
  end

endmodule
`default_nettype wire

### hdl/first_fit_segment_allocator.sv
// A transaction runs through a clear, a scan of every cell and a decision; a release
// that merges with its predecessor adds a predecessor step. in_tready stays low until
// the transaction is done, and the decision waits while a result waits on out_tready.
// During the scan the first-match token ripples one cell per cycle down the segment chain.
// Reset (rst_n low, synchronous): one free segment covering all units.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator #(
  parameter int MEM_UNITS    = ffsa_pkg::MEM_UNITS_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // request_size[7:0], task_id[15:8]
  input  wire logic [0:0]  in_tuser,   // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // status[1:0], base_address[8:2]
);

  localparam int AW   = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int LW   = $clog2(MEM_UNITS + 1);
  localparam int NW   = AW + LW + 14;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_PRED   = 2'd3;

  typedef struct packed {
    logic          valid;
    logic          used;
    logic [7:0]    owner;
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic          hit;
    logic          first;
    logic          seen;
    logic          mark;
  } node_t;

  node_t nodes [MAX_SEGMENTS];
  ffsa_pkg::cmd_t cmd;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            func_r;
  logic [7:0]      size_r, id_r;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [6:0]      base_r, base_nxt;

  logic            any, succ_free, pred_free, exact, out_free;
  logic [AW-1:0]   sel_start;
  logic [LW-1:0]   sel_len;
  logic [AW+6:0]   base_ext;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      logic [NW-1:0] prev_w, next_w, self_w;
      if (g == 0) begin : g_head
        assign prev_w = '0;
      end else begin : g_body
        assign prev_w = nodes[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_tail
        assign next_w = '0;
      end else begin : g_mid
        assign next_w = nodes[g+1];
      end
      ffsa_cell #(
        .MEM_UNITS(MEM_UNITS),
        .HEAD     (g == 0)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .prev_i(prev_w),
        .next_i(next_w),
        .self_o(self_w)
      );
      assign nodes[g] = node_t'(self_w);
    end
  endgenerate

  always_comb begin
    any       = 1'b0;
    succ_free = 1'b0;
    pred_free = 1'b0;
    sel_start = '0;
    sel_len   = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      any       = any | nodes[i].first;
      sel_start = sel_start | ({AW{nodes[i].first}} & nodes[i].start);
      sel_len   = sel_len | ({LW{nodes[i].first}} & nodes[i].len);
      if (i < MAX_SEGMENTS - 1) begin
        succ_free = succ_free | (nodes[i].first & nodes[(i < MAX_SEGMENTS - 1) ? i + 1 : i].valid
                                 & ~nodes[(i < MAX_SEGMENTS - 1) ? i + 1 : i].used);
      end
      if (i > 0) begin
        pred_free = pred_free | (nodes[i].first & ~nodes[(i > 0) ? i - 1 : i].used);
      end
    end
  end

  assign exact    = ((LW + 8)'(sel_len) == (LW + 8)'(size_r));
  assign base_ext = {7'd0, sel_start};
  assign out_free = ~out_valid_r | out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    status_nxt    = status_r;
    base_nxt      = base_r;
    cmd.op        = ffsa_pkg::OP_NONE;
    cmd.func      = func_r;
    cmd.split     = 1'b0;
    cmd.merge     = 1'b0;
    cmd.size      = size_r;
    cmd.id        = id_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = ffsa_pkg::OP_CLEAR;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op  = ffsa_pkg::OP_SCAN;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(MAX_SEGMENTS - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          base_nxt      = 7'd0;
          state_nxt     = S_IDLE;
          if (func_r == ffsa_pkg::FUNC_ALLOC) begin
            if (!any) begin
              status_nxt = ffsa_pkg::ST_NOFIT;
            end else if (!exact && nodes[MAX_SEGMENTS-1].valid) begin
              status_nxt = ffsa_pkg::ST_FULL;
            end else begin
              status_nxt = ffsa_pkg::ST_OK;
              base_nxt   = base_ext[6:0];
              cmd.op     = ffsa_pkg::OP_ALLOC;
              cmd.split  = ~exact;
            end
          end else begin
            if (!any) begin
              status_nxt = ffsa_pkg::ST_NOTASK;
            end else begin
              status_nxt = ffsa_pkg::ST_OK;
              base_nxt   = base_ext[6:0];
              cmd.op     = ffsa_pkg::OP_REL;
              cmd.merge  = succ_free;
              if (pred_free) state_nxt = S_PRED;
            end
          end
        end
      end
      S_PRED: begin
        cmd.op    = ffsa_pkg::OP_PRED;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    base_r   <= base_nxt;
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser[0];
      size_r <= in_tdata[7:0];
      id_r   <= in_tdata[15:8];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, base_r, status_r};

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NUM_UNITS = 128;
  localparam int NUM_SEGS  = 16;
  localparam int N_RANDOM  = 1730;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic       func;
    logic [7:0] size;
    logic [7:0] id;
  } request_t;

  typedef struct packed {
    logic [6:0] base;
    logic [1:0] status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  first_fit_segment_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // segment table mirror
  int         seg_start [NUM_SEGS];
  int         seg_len   [NUM_SEGS];
  bit         seg_used  [NUM_SEGS];
  logic [7:0] seg_owner [NUM_SEGS];
  int         seg_count;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int  errors = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  st_hist[4] = '{0, 0, 0, 0};
  bit  quiet_phase = 1'b0;
  bit  hold_send = 1'b0;
  bit  stim_done = 1'b0;
  int  idle_cnt = 0;

  function automatic void table_reset();
    seg_count = 1;
    seg_start[0] = 0;
    seg_len[0] = NUM_UNITS;
    seg_used[0] = 1'b0;
    seg_owner[0] = '0;
  endfunction

  function automatic void remove_seg(int idx);
    for (int k = idx; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
      seg_used[k]  = seg_used[k+1];
      seg_owner[k] = seg_owner[k+1];
    end
    seg_count--;
  endfunction

  function automatic answer_t serve_request(request_t r);
    answer_t a;
    int i;
    a.status = ffsa_pkg::ST_OK;
    a.base = '0;
    if (r.func == ffsa_pkg::FUNC_ALLOC) begin
      for (i = 0; i < seg_count; i++)
        if (!seg_used[i] && seg_len[i] >= r.size) break;
      if (r.size == 0 || i >= seg_count) begin
        a.status = ffsa_pkg::ST_NOFIT;
      end else if (seg_len[i] != r.size && seg_count >= NUM_SEGS) begin
        a.status = ffsa_pkg::ST_FULL;
      end else begin
        if (seg_len[i] != r.size) begin
          for (int k = seg_count; k > i + 1; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_len[k]   = seg_len[k-1];
            seg_used[k]  = seg_used[k-1];
            seg_owner[k] = seg_owner[k-1];
          end
          seg_start[i+1] = seg_start[i] + r.size;
          seg_len[i+1] = seg_len[i] - r.size;
          seg_used[i+1] = 1'b0;
          seg_owner[i+1] = '0;
          seg_len[i] = r.size;
          seg_count++;
        end
        seg_used[i] = 1'b1;
        seg_owner[i] = r.id;
        a.base = seg_start[i][6:0];
      end
    end else begin
      for (i = 0; i < seg_count; i++)
        if (seg_used[i] && seg_owner[i] == r.id) break;
      if (i >= seg_count) begin
        a.status = ffsa_pkg::ST_NOTASK;
      end else begin
        a.base = seg_start[i][6:0];
        seg_used[i] = 1'b0;
        seg_owner[i] = '0;
        if (i + 1 < seg_count && !seg_used[i+1]) begin
          seg_len[i] += seg_len[i+1];
          remove_seg(i + 1);
        end
        if (i > 0 && !seg_used[i-1]) begin
          seg_len[i-1] += seg_len[i];
          remove_seg(i);
        end
      end
    end
    return a;
  endfunction

  function automatic request_t mk(logic f, int sz, int id);
    request_t r;
    r.func = f;
    r.size = sz[7:0];
    r.id = id[7:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_answers.push_back(serve_request(pending_reqs.pop_front()));
      n_sent++;
    end
    if ((!in_tvalid || in_tready) && rst_n) begin
      if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0) && !hold_send &&
          (quiet_phase || $urandom_range(99) >= 23)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_reqs[0].id, pending_reqs[0].size};
        in_tuser <= pending_reqs[0].func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, exp_a;
    if (out_tvalid && out_tready) begin
      got = out_tdata[8:0];
      n_recv++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d base=%0d", $time, got.status, got.base);
        errors++;
      end else begin
        exp_a = expected_answers.pop_front();
        st_hist[got.status]++;
        if (got.status !== exp_a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status, got.status);
          errors++;
        end
        if (got.base !== exp_a.base) begin
          $display("%0t: base expected %0d actual %0d", $time, exp_a.base, got.base);
          errors++;
        end
      end
    end
    out_tready <= rst_n && (quiet_phase || $urandom_range(99) >= 23);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_MAX) begin
      $display("timeout with %0d results outstanding", expected_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int id_pool;
    table_reset();
    // directed: extremes, exact fit, table full, unknown task, duplicate owners
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 0, 1));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 255, 2));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_RELEASE, 0, 9));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 128, 255));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 1, 3));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_RELEASE, 255, 255));
    for (int k = 0; k < 15; k++) pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 1, 7));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 1, 8));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC, 113, 8));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_RELEASE, 170, 7));
    pending_reqs.push_back(mk(ffsa_pkg::FUNC_RELEASE, 0, 8));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 400) begin
        wait (pending_reqs.size() == 0 && !in_tvalid);
        hold_send = 1'b1;
        wait (expected_answers.size() == 0);
        hold_send = 1'b0;
        quiet_phase = 1'b1;
      end
      if (k == 700) quiet_phase = 1'b0;
      id_pool = (k / 300) % 2 ? 255 : 7;
      case ($urandom_range(9))
        0: pending_reqs.push_back(mk($urandom_range(1), $urandom_range(255),
                                     $urandom_range(255)));
        1, 2, 3, 4, 5: pending_reqs.push_back(mk(ffsa_pkg::FUNC_ALLOC,
            $urandom_range(1) ? $urandom_range(1, 16) : $urandom_range(0, 128),
            $urandom_range(id_pool)));
        default: pending_reqs.push_back(mk(ffsa_pkg::FUNC_RELEASE, $urandom_range(255),
                                           $urandom_range(id_pool)));
      endcase
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    stim_done = 1'b1;
    wait (pending_reqs.size() == 0 && !in_tvalid && expected_answers.size() == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d requests, checked %0d results", n_sent, n_recv);
    $display("ok %0d, no fit %0d, task not found %0d, table full %0d",
             st_hist[0], st_hist[1], st_hist[2], st_hist[3]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
